>>> sv/dmx512_frame_transmitter_defines.svh
// Assertion macros used by the DMX512 transmitter RTL.
`ifndef DMX512_FRAME_TRANSMITTER_DEFINES_SVH
`define DMX512_FRAME_TRANSMITTER_DEFINES_SVH

// Checked on every clock edge outside reset.
`define DMX_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define DMX_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/dmx_pkg.sv
// Package: widths, sequence codes and defaults of the DMX512 transmitter.
`timescale 1ns / 1ps
package dmx_pkg;

    localparam int CHAN_W           = 10;
    localparam int LEVEL_W          = 8;
    localparam int KIND_W           = 2;
    localparam int PHASE_W          = 2;

    localparam int MAX_CHANNELS_DEF = 512;
    localparam int INITIAL_HIGHEST  = 32;

    // Frame sequence phases
    localparam logic [PHASE_W-1:0] PHASE_BREAK = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_START = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_DATA  = 2'd2;

    // Symbol kinds
    localparam logic [KIND_W-1:0] KIND_BREAK = 2'd0;
    localparam logic [KIND_W-1:0] KIND_START = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DATA  = 2'd2;

    // Command opcodes
    localparam logic OP_STORE = 1'b0;
    localparam logic OP_READY = 1'b1;

endpackage

>>> sv/dmx_cmd_if.sv
// Command channel: level stores and transmitter-ready items.
`timescale 1ns / 1ps
interface dmx_cmd_if
    import dmx_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [CHAN_W-1:0]  channel;
    logic [LEVEL_W-1:0] level;

    modport source (output valid, output opcode, output channel, output level, input ready);
    modport sink   (input valid, input opcode, input channel, input level, output ready);
endinterface

>>> sv/dmx_sym_if.sv
// Symbol channel: one DMX512 symbol per item.
`timescale 1ns / 1ps
interface dmx_sym_if
    import dmx_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  symbol_kind;
    logic [LEVEL_W-1:0] out_byte;
    logic               frame_end;

    modport source (output valid, output symbol_kind, output out_byte, output frame_end,
                    input ready);
    modport sink   (input valid, input symbol_kind, input out_byte, input frame_end,
                    output ready);
endinterface

>>> sv/dmx512_frame_transmitter.sv
// Top level: DMX512 frame sequencer around a channel level RAM.
//
//  Channel | Role   | Payload                       | Results
//  --------+--------+-------------------------------+-------------------------------
//  cmd     | sink   | opcode, channel, level        | store: none, ready: one symbol
//  sym     | source | symbol_kind, out_byte, frame_end | one per ready item
//
//  One item per cycle sustained while cmd is not stalled; a ready item is held in the read
//  stage while the RAM is read at acceptance, then loaded into the symbol register once that is empty or being taken.
//  The single RAM port takes one store write or one data read per cycle.
//  After reset a clearing pass writes zeros to all MAX_CHANNELS entries,
//  one per cycle; cmd.ready stays low until the pass is done.
//  A full symbol register with a waiting result stalls cmd; one more item
//  is still taken into the read stage while the symbol waits.
`timescale 1ns / 1ps
`include "dmx512_frame_transmitter_defines.svh"
module dmx512_frame_transmitter
    import dmx_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    dmx_cmd_if.sink     cmd,
    dmx_sym_if.source   sym
);
    localparam int ADDR_W = $clog2(MAX_CHANNELS);
    localparam logic [CHAN_W-1:0] MAX_CHAN = CHAN_W'(MAX_CHANNELS);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_CHANNELS - 1);

    // Clearing pass
    logic              clr_reg,      clr_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;

    // Frame sequence
    logic [PHASE_W-1:0] phase_reg,   phase_next;
    logic [CHAN_W-1:0]  pos_reg,     pos_next;
    logic [CHAN_W-1:0]  highest_reg, highest_next;

    // Read stage: a symbol on its way to the symbol register, with RAM data for data symbols
    logic              pend_reg,      pend_next;
    logic [KIND_W-1:0] pend_kind_reg, pend_kind_next;
    logic              pend_end_reg,  pend_end_next;
    logic              pend_mem_reg,  pend_mem_next;

    // Symbol register
    logic               out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]  out_kind_reg,  out_kind_next;
    logic [LEVEL_W-1:0] out_byte_reg,  out_byte_next;
    logic               out_end_reg,   out_end_next;

    logic               accept;
    logic               pend_move;
    logic [CHAN_W-1:0]  chan_clamped;
    logic [CHAN_W-1:0]  pos_inc;
    logic               ram_en;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_addr;
    logic [LEVEL_W-1:0] ram_wdata;
    logic [LEVEL_W-1:0] ram_rdata;

    assign pend_move  = pend_reg && (!out_valid_reg || sym.ready);
    assign cmd.ready  = !clr_reg && (!pend_reg || !out_valid_reg || sym.ready);
    assign accept     = cmd.valid && cmd.ready;

    assign sym.valid       = out_valid_reg;
    assign sym.symbol_kind = out_kind_reg;
    assign sym.out_byte    = out_byte_reg;
    assign sym.frame_end   = out_end_reg;

    // Store channel clamped to 1..MAX_CHANNELS
    always_comb
    begin
        if (cmd.channel == '0)
        begin
            chan_clamped = CHAN_W'(1);
        end
        else if (cmd.channel > MAX_CHAN)
        begin
            chan_clamped = MAX_CHAN;
        end
        else
        begin
            chan_clamped = cmd.channel;
        end
    end

    assign pos_inc = pos_reg + CHAN_W'(1);

    always_comb
    begin
        clr_next       = clr_reg;
        clr_addr_next  = clr_addr_reg;
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        highest_next   = highest_reg;
        pend_next      = pend_reg;
        pend_kind_next = pend_kind_reg;
        pend_end_next  = pend_end_reg;
        pend_mem_next  = pend_mem_reg;
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_byte_next  = out_byte_reg;
        out_end_next   = out_end_reg;
        ram_en         = 1'b0;
        ram_we         = 1'b0;
        ram_addr       = clr_addr_reg;
        ram_wdata      = '0;

        if (clr_reg)
        begin
            ram_en        = 1'b1;
            ram_we        = 1'b1;
            clr_addr_next = clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == LAST_ADDR)
            begin
                clr_next = 1'b0;
            end
        end

        // Symbol register drains, then refills from the read stage
        if (sym.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (pend_move)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = pend_kind_reg;
            out_byte_next  = pend_mem_reg ? ram_rdata : '0;
            out_end_next   = pend_end_reg;
            pend_next      = 1'b0;
        end

        if (accept)
        begin
            if (cmd.opcode == OP_STORE)
            begin
                ram_en    = 1'b1;
                ram_we    = 1'b1;
                ram_addr  = ADDR_W'(chan_clamped - CHAN_W'(1));
                ram_wdata = cmd.level;
                if (chan_clamped > highest_reg && chan_clamped < MAX_CHAN)
                begin
                    highest_next = chan_clamped;
                end
            end
            else
            begin
                pend_next = 1'b1;
                case (phase_reg)
                    PHASE_START:
                    begin
                        pend_kind_next = KIND_START;
                        pend_end_next  = 1'b0;
                        pend_mem_next  = 1'b0;
                        phase_next     = PHASE_DATA;
                        pos_next       = CHAN_W'(1);
                    end
                    PHASE_DATA:
                    begin
                        ram_en         = 1'b1;
                        ram_addr       = ADDR_W'(pos_reg - CHAN_W'(1));
                        pend_kind_next = KIND_DATA;
                        pend_mem_next  = 1'b1;
                        pos_next       = pos_inc;
                        pend_end_next  = (pos_inc > highest_reg) || (pos_inc == '0);
                        if (pend_end_next)
                        begin
                            phase_next = PHASE_BREAK;
                        end
                    end
                    default:
                    begin
                        pend_kind_next = KIND_BREAK;
                        pend_end_next  = 1'b0;
                        pend_mem_next  = 1'b0;
                        phase_next     = PHASE_START;
                        pos_next       = '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= 1'b1;
            clr_addr_reg  <= '0;
            phase_reg     <= PHASE_BREAK;
            pos_reg       <= '0;
            highest_reg   <= CHAN_W'(INITIAL_HIGHEST);
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_reg       <= clr_next;
            clr_addr_reg  <= clr_addr_next;
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            highest_reg   <= highest_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_kind_reg <= pend_kind_next;
        pend_end_reg  <= pend_end_next;
        pend_mem_reg  <= pend_mem_next;
        out_kind_reg  <= out_kind_next;
        out_byte_reg  <= out_byte_next;
        out_end_reg   <= out_end_next;
    end

    dmx_ram #(
        .WIDTH (LEVEL_W),
        .DEPTH (MAX_CHANNELS)
    ) u_level_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // No item is taken while the RAM is being cleared
    `DMX_ASSERT_ALWAYS(a_no_accept_in_clear, clr_reg |-> !cmd.ready, "item accepted during clear")
    // Highest channel never shrinks
    `DMX_ASSERT(a_highest_monotonic, 1'b1 |=> highest_reg >= $past(highest_reg), "highest shrank")
    // Highest channel stays below the top, except for its reset value
    `DMX_ASSERT(a_highest_range, (highest_reg < MAX_CHAN) || (highest_reg == CHAN_W'(INITIAL_HIGHEST)), "highest out of range")
    // Frame end only ever marks a data byte
    `DMX_ASSERT(a_end_on_data, (out_valid_reg && out_end_reg) |-> (out_kind_reg == KIND_DATA), "frame end on non-data")
endmodule

>>> sv/dmx_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module dmx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end
endmodule

>>> bench/tb_top.sv
// Self-checking bench for the DMX512 frame transmitter: directed table, random run, live scoreboard.
`timescale 1ns / 1ps
module tb_top;
    import dmx_pkg::*;

    localparam int MAXC          = MAX_CHANNELS_DEF;
    localparam int RANDOM_ITEMS  = 1728;
    // Tail of the random run where stores may land anywhere in the channel field.
    localparam int WIDE_TAIL     = 300;
    // Sender runs without gaps over this window of random items.
    localparam int SEND_CALM_LO  = 900;
    localparam int SEND_CALM_HI  = 1200;
    // Receiver schedule, in cycles after reset release: one long hold-off, one gap-free window.
    localparam int HOLD_START    = 1100;
    localparam int HOLD_CYCLES   = 300;
    localparam int SINK_CALM_LO  = 1700;
    localparam int SINK_CALM_HI  = 2000;
    localparam int DRAIN_CYCLES  = 16;
    localparam int IDLE_PERCENT  = 6;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [LEVEL_W-1:0] data;
        logic               last;
    } symbol_t;

    typedef struct packed {
        logic               op;
        logic [CHAN_W-1:0]  chan;
        logic [LEVEL_W-1:0] lvl;
        bit                 typed;
        symbol_t            want;
    } script_row_t;

    localparam int N_DIRECTED = 22;

    // Hand-written opening sequence. Rows marked typed carry their symbol as read off the
    // frame format; the rest fall back on the frame predictor.
    localparam script_row_t DIRECTED [N_DIRECTED] = '{
        // first frame after reset: break, then start code
        '{OP_READY, 10'd0,    8'h00, 1'b1, '{KIND_BREAK, 8'h00, 1'b0}},
        '{OP_READY, 10'd0,    8'h00, 1'b1, '{KIND_START, 8'h00, 1'b0}},
        // channel zero clamps to channel 1, stored before channel 1 goes out
        '{OP_STORE, 10'd0,    8'hFF, 1'b0, '0},
        // above range clamps to the top channel; top channel never raises the frame length
        '{OP_STORE, 10'd1023, 8'hA5, 1'b0, '0},
        '{OP_STORE, 10'd512,  8'h5A, 1'b0, '0},
        '{OP_STORE, 10'd2,    8'h3C, 1'b0, '0},
        '{OP_READY, 10'd0,    8'h00, 1'b1, '{KIND_DATA,  8'hFF, 1'b0}},
        // channel 1 already went out this frame
        '{OP_STORE, 10'd1,    8'h11, 1'b0, '0},
        '{OP_READY, 10'd0,    8'h00, 1'b1, '{KIND_DATA,  8'h3C, 1'b0}},
        // one above the reset length raises it; the old length itself does not
        '{OP_STORE, 10'd33,   8'h80, 1'b0, '0},
        '{OP_STORE, 10'd32,   8'h7F, 1'b0, '0},
        '{OP_STORE, 10'd3,    8'h00, 1'b0, '0},
        '{OP_STORE, 10'd4,    8'hFF, 1'b0, '0},
        '{OP_READY, 10'd0,    8'h00, 1'b1, '{KIND_DATA,  8'h00, 1'b0}},
        '{OP_READY, 10'd0,    8'h00, 1'b1, '{KIND_DATA,  8'hFF, 1'b0}},
        '{OP_STORE, 10'd1023, 8'h00, 1'b0, '0},
        '{OP_STORE, 10'd0,    8'h00, 1'b0, '0},
        '{OP_STORE, 10'd5,    8'h55, 1'b0, '0},
        '{OP_READY, 10'd0,    8'h00, 1'b0, '0},
        '{OP_READY, 10'd0,    8'h00, 1'b0, '0},
        '{OP_STORE, 10'd34,   8'hC3, 1'b0, '0},
        '{OP_READY, 10'd0,    8'h00, 1'b0, '0}
    };

    logic clk = 1'b0;
    logic rst_n;

    dmx_cmd_if cmd_bus ();
    dmx_sym_if sym_bus ();

    dmx512_frame_transmitter #(
        .MAX_CHANNELS (MAXC)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .sym   (sym_bus)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mirror of the transmitter state, advanced once per accepted command item.
    logic [LEVEL_W-1:0] level_mirror [MAXC];
    logic [PHASE_W-1:0] phase_mirror;
    logic [CHAN_W-1:0]  position_mirror;
    logic [CHAN_W-1:0]  highest_mirror;

    // Symbols predicted but not yet seen on the symbol channel, oldest first.
    symbol_t pending_symbols [$];

    int err_count;
    int n_stores;
    int n_readies;
    int n_symbols;
    int n_frames;

    // Apply one command item to the mirror; a ready item yields the next symbol of the frame.
    task automatic frame_step(input logic op, input logic [CHAN_W-1:0] chan,
                              input logic [LEVEL_W-1:0] lvl,
                              output bit emits, output symbol_t sym_out);
        int unsigned target;
        int unsigned idx;
        emits   = 1'b0;
        sym_out = '0;
        if (op == OP_STORE)
        begin
            target = chan;
            if (target < 1)
                target = 1;
            if (target > MAXC)
                target = MAXC;
            level_mirror[target - 1] = lvl;
            // top channel keeps its level but never stretches the frame
            if (target > highest_mirror && target < MAXC)
                highest_mirror = CHAN_W'(target);
        end
        else
        begin
            emits = 1'b1;
            case (phase_mirror)
                PHASE_START:
                begin
                    sym_out.kind    = KIND_START;
                    phase_mirror    = PHASE_DATA;
                    position_mirror = CHAN_W'(1);
                end
                PHASE_DATA:
                begin
                    idx = (position_mirror >= 1 && position_mirror <= MAXC) ?
                          position_mirror - 1 : 0;
                    sym_out.kind    = KIND_DATA;
                    sym_out.data    = level_mirror[idx];
                    position_mirror = position_mirror + 1'b1;
                    if (position_mirror > highest_mirror || position_mirror == '0)
                    begin
                        sym_out.last = 1'b1;
                        phase_mirror = PHASE_BREAK;
                    end
                end
                // break next; the unused phase code behaves the same
                default:
                begin
                    sym_out.kind    = KIND_BREAK;
                    phase_mirror    = PHASE_START;
                    position_mirror = '0;
                end
            endcase
        end
    endtask

    // Hold one item on cmd until taken, then feed it to the mirror. A typed row overrides
    // the predicted symbol with its own.
    task automatic offer_item(input logic op, input logic [CHAN_W-1:0] chan,
                              input logic [LEVEL_W-1:0] lvl,
                              input bit typed, input symbol_t typed_sym);
        bit      emits;
        symbol_t predicted;
        cmd_bus.valid   <= 1'b1;
        cmd_bus.opcode  <= op;
        cmd_bus.channel <= chan;
        cmd_bus.level   <= lvl;
        @(posedge clk);
        while (!cmd_bus.ready)
            @(posedge clk);
        frame_step(op, chan, lvl, emits, predicted);
        if (emits)
            pending_symbols.push_back(typed ? typed_sym : predicted);
        if (op == OP_STORE)
            n_stores++;
        else
            n_readies++;
    endtask

    // Sender gap after an item: each cycle idles with a small chance.
    task automatic sender_gap(input bit calm);
        if (!calm)
        begin
            while ($urandom_range(99) < IDLE_PERCENT)
            begin
                cmd_bus.valid <= 1'b0;
                @(posedge clk);
            end
        end
    endtask

    // Command side: reset, directed table, random run, drain, verdict.
    initial
    begin : command_side
        logic               op;
        logic [CHAN_W-1:0]  chan;
        logic [LEVEL_W-1:0] lvl;
        int unsigned        pick;
        bit                 wide;

        err_count = 0;
        n_stores  = 0;
        n_readies = 0;
        n_symbols = 0;
        n_frames  = 0;
        foreach (level_mirror[i])
            level_mirror[i] = '0;
        phase_mirror    = PHASE_BREAK;
        position_mirror = '0;
        highest_mirror  = CHAN_W'(INITIAL_HIGHEST);

        rst_n           <= 1'b0;
        cmd_bus.valid   <= 1'b0;
        cmd_bus.opcode  <= OP_STORE;
        cmd_bus.channel <= '0;
        cmd_bus.level   <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        // the clearing pass after reset shows up as cmd.ready low; offer_item waits it out
        @(posedge clk);

        for (int r = 0; r < N_DIRECTED; r++)
        begin
            offer_item(DIRECTED[r].op, DIRECTED[r].chan, DIRECTED[r].lvl,
                       DIRECTED[r].typed, DIRECTED[r].want);
            sender_gap(1'b0);
        end

        // Random run. Most stores stay inside the current frame so frames stay short and
        // many frame ends are seen; a few stretch the frame by a handful of channels, and
        // a few land at or above the top channel. Only the tail may store anywhere in the field.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            wide = (n >= RANDOM_ITEMS - WIDE_TAIL);
            op   = ($urandom_range(99) < 55) ? OP_READY : OP_STORE;
            chan = CHAN_W'($urandom_range(1023, 0));
            lvl  = LEVEL_W'($urandom_range(255, 0));
            if (op == OP_STORE)
            begin
                pick = $urandom_range(99);
                if (pick < 6)
                    chan = wide ? CHAN_W'($urandom_range(1023, 0))
                                : CHAN_W'($urandom_range(1023, MAXC));
                else if (pick < 9)
                    chan = CHAN_W'(highest_mirror + $urandom_range(8, 1));
                else
                    chan = CHAN_W'($urandom_range(highest_mirror, 0));
            end
            offer_item(op, chan, lvl, 1'b0, '0);
            sender_gap(n >= SEND_CALM_LO && n < SEND_CALM_HI);
        end
        cmd_bus.valid <= 1'b0;

        while (pending_symbols.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run: %0d stores and %0d ready items sent, %0d symbols checked",
                 n_stores, n_readies, n_symbols);
        $display("run: %0d complete frames, frame length grew to %0d channels",
                 n_frames, highest_mirror);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Symbol side back-pressure: random stalls, one long hold-off that backs the block
    // up into cmd, and a window with no stalls at all.
    initial
    begin : symbol_side
        int unsigned cyc;
        cyc = 0;
        sym_bus.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_CYCLES)
                sym_bus.ready <= 1'b0;
            else if (cyc >= SINK_CALM_LO && cyc < SINK_CALM_HI)
                sym_bus.ready <= 1'b1;
            else
                sym_bus.ready <= ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Scoreboard: every symbol taken must match the oldest pending prediction.
    always @(posedge clk)
    begin : symbol_check
        symbol_t want;
        if (rst_n === 1'b1 && sym_bus.valid === 1'b1 && sym_bus.ready === 1'b1)
        begin
            if (pending_symbols.size() == 0)
            begin
                $error("symbol with none pending: kind=%0d byte=%02h end=%0b",
                       sym_bus.symbol_kind, sym_bus.out_byte, sym_bus.frame_end);
                err_count++;
            end
            else
            begin
                want = pending_symbols.pop_front();
                if (sym_bus.symbol_kind !== want.kind)
                begin
                    $error("symbol_kind: expected %0d, got %0d", want.kind, sym_bus.symbol_kind);
                    err_count++;
                end
                if (sym_bus.out_byte !== want.data)
                begin
                    $error("out_byte: expected %02h, got %02h", want.data, sym_bus.out_byte);
                    err_count++;
                end
                if (sym_bus.frame_end !== want.last)
                begin
                    $error("frame_end: expected %0b, got %0b", want.last, sym_bus.frame_end);
                    err_count++;
                end
                n_symbols++;
                if (want.last)
                    n_frames++;
            end
        end
    end

    // Hard stop far beyond the slowest legal run.
    initial
    begin : watchdog
        #1_000_000;
        $display("timeout: %0d symbols still pending", pending_symbols.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> sim.f
+incdir+sv
sv/dmx_pkg.sv
sv/dmx_cmd_if.sv
sv/dmx_sym_if.sv
sv/dmx_ram.sv
sv/dmx512_frame_transmitter.sv
bench/tb_top.sv
